[design/lpl_pkg.sv]
// Shared constants and types for the look-ahead peak limiter.
`default_nettype none

package lpl_pkg;

    localparam int GAIN_W     = 24;
    localparam int GAIN_FRAC  = 23;
    localparam int COEFF_W    = 25;
    localparam int COEFF_FRAC = 24;
    localparam int MUL_B_W    = COEFF_W + 1;
    localparam int THR_W      = 24;
    localparam int DLY_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN = 24'd8388608;
    localparam logic [COEFF_W-1:0] COEFF_ONE  = 25'd16777216;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = 3'd5;

    localparam logic                 RST_ENABLE    = 1'b1;
    localparam logic                 RST_STEREO    = 1'b1;
    localparam logic [THR_W-1:0]     RST_THRESHOLD = 24'd7919358;
    localparam logic [COEFF_W-1:0]   RST_ATTACK    = 25'd75915;
    localparam logic [COEFF_W-1:0]   RST_RELEASE   = 25'd7607;
    localparam logic [DLY_W-1:0]     RST_DELAY     = 11'd128;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_ENV_MUL  = 9'b000000010,
        S_ENV_UPD  = 9'b000000100,
        S_GAIN_CHK = 9'b000001000,
        S_DIV      = 9'b000010000,
        S_MUL_L    = 9'b000100000,
        S_MUL_R    = 9'b001000000,
        S_FIN      = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

endpackage

`default_nettype wire

[design/lpl_in_if.sv]
// Input frame channel: valid/ready handshake with left and right samples.
`default_nettype none

interface lpl_in_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;

    modport source (output valid, output sample_left, output sample_right, input ready);
    modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

`default_nettype wire

[design/lpl_out_if.sv]
// Result channel: valid/ready handshake with limited samples and applied gain.
`default_nettype none

interface lpl_out_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic [23:0]                   gain_applied;

    modport source (output valid, output out_left, output out_right, output gain_applied,
                    input ready);
    modport sink   (input valid, input out_left, input out_right, input gain_applied,
                    output ready);
endinterface

`default_nettype wire

[design/lookahead_peak_limiter_core.sv]
// Look-ahead peak limiter core: sequencer, envelope, delay ring and gain stage.
//
// Usage: frames enter on i_frame (valid/ready), one left/right sample pair per
// request; results leave on o_result (valid/ready) with the delayed, gained
// samples and the gain used. Registers are written through i_cfg_we/i_cfg_idx/
// i_cfg_data; the user must do so only while the block is idle, the block itself
// does not enforce it. When the envelope is above the threshold the sequencer
// waits on the bit-serial divider; disabled frames skip the envelope and gain
// steps. The block takes one frame at a time: the input reopens in the cycle
// after the result is loaded into the output register.
// One multiplier is shared for the envelope step and both gain products; the
// divider computes threshold/envelope.
// Reset (synchronous, active low) loads default registers, clears envelope,
// ring position and the ring-valid flag; no memory sweep is needed since an
// unwrapped ring reads as silence.
// A stalled receiver holds the result in the output register; the core can
// still take and process one more frame, then waits until the slot frees.
`default_nettype none

module lookahead_peak_limiter_core
    import lpl_pkg::*;
#(
    parameter int MAX_DELAY   = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    lpl_in_if.sink                     i_frame,
    lpl_out_if.source                  o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SB = SAMPLE_BITS;
    localparam int PW = $clog2(MAX_DELAY);
    localparam int DW = $clog2(MAX_DELAY + 1);
    localparam int AW = SB + 1;
    localparam int MW = AW + MUL_B_W;

    // configuration
    logic                r_en;
    logic                r_st;
    logic [THR_W-1:0]    r_thr;
    logic [COEFF_W-1:0]  r_att;
    logic [COEFF_W-1:0]  r_rel;
    logic [DLY_W-1:0]    r_dly;

    t_state              r_state;
    t_state              n_state;

    logic signed [SB-1:0] r_l;
    logic signed [SB-1:0] r_r;
    logic [SB-1:0]        r_peak;
    logic [SB-1:0]        r_env;
    logic [PW-1:0]        r_pos;
    logic                 r_wrapped;
    logic signed [SB-1:0] r_dl;
    logic signed [SB-1:0] r_dr;
    logic [GAIN_W-1:0]    r_gain;
    logic signed [SB-1:0] r_res_l;
    logic signed [SB-1:0] r_res_r;

    logic                 r_ov;
    logic signed [SB-1:0] r_out_l;
    logic signed [SB-1:0] r_out_r;
    logic [GAIN_W-1:0]    r_out_g;

    logic                 in_accept;
    logic                 out_free;
    logic                 cfg_clear;

    logic [SB:0]          ext_l;
    logic [SB:0]          ext_r;
    logic [SB:0]          abs_l;
    logic [SB:0]          abs_r;
    logic signed [SB-1:0] in_r_eff;
    logic [SB-1:0]        in_peak;

    logic [THR_W-1:0]     tthr;
    logic [COEFF_W-1:0]   ta;
    logic [COEFF_W-1:0]   tr;
    logic [31:0]          dly_ext;
    logic [DW-1:0]        dly;
    logic                 dly_zero;
    logic [SB+THR_W-1:0]  thr_wide;
    logic [SB-1:0]        thr;

    logic                 env_up;
    logic [SB-1:0]        env_diff;
    logic [SB-1:0]        env_step;
    logic [SB-1:0]        env_next;

    logic [DW-1:0]        pos_inc;
    logic                 pos_wrap;

    logic signed [AW-1:0]      mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MW-1:0]      mul_p;
    logic signed [SB-1:0]      mul_gained;

    logic                 div_start;
    logic                 div_done;
    logic [GAIN_FRAC-1:0] div_quot;

    logic [2*SB-1:0]      ring_rdata;
    logic                 ring_we;

    assign in_accept = i_frame.valid && i_frame.ready;
    assign out_free  = !r_ov || o_result.ready;
    assign cfg_clear = i_cfg_we && (((i_cfg_idx == CFG_ENABLE) && !i_cfg_data[0])
                                    || (i_cfg_idx == CFG_DELAY));

    // input magnitudes
    assign ext_l    = {i_frame.sample_left[SB-1], i_frame.sample_left};
    assign in_r_eff = r_st ? i_frame.sample_right : '0;
    assign ext_r    = {in_r_eff[SB-1], in_r_eff};
    assign abs_l    = ext_l[SB] ? (~ext_l + 1'b1) : ext_l;
    assign abs_r    = ext_r[SB] ? (~ext_r + 1'b1) : ext_r;
    assign in_peak  = (abs_r[SB-1:0] > abs_l[SB-1:0]) ? abs_r[SB-1:0] : abs_l[SB-1:0];

    // saturated settings
    assign tthr     = (r_thr > UNITY_GAIN) ? UNITY_GAIN : r_thr;
    assign ta       = (r_att > COEFF_ONE) ? COEFF_ONE : r_att;
    assign tr       = (r_rel > COEFF_ONE) ? COEFF_ONE : r_rel;
    assign dly_ext  = 32'(r_dly);
    assign dly      = (dly_ext > 32'(MAX_DELAY)) ? DW'(MAX_DELAY) : DW'(dly_ext);
    assign dly_zero = (dly == '0);
    assign thr_wide = {{SB{1'b0}}, tthr} << (SB - 1);
    assign thr      = thr_wide[SB+GAIN_FRAC-1:GAIN_FRAC];

    // envelope follower
    assign env_up   = r_peak > r_env;
    assign env_diff = env_up ? (r_peak - r_env) : (r_env - r_peak);
    assign env_step = mul_p[SB+COEFF_FRAC-1:COEFF_FRAC];
    assign env_next = env_up ? (r_env + env_step) : (r_env - env_step);

    assign pos_inc  = DW'(r_pos) + DW'(1);
    assign pos_wrap = (pos_inc == dly);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_ENV_MUL: begin
                mul_a = $signed({1'b0, env_diff});
                mul_b = $signed({1'b0, (env_up ? ta : tr)});
            end
            S_MUL_L: begin
                mul_a = $signed({r_dl[SB-1], r_dl});
                mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, r_gain});
            end
            S_MUL_R: begin
                mul_a = $signed({r_dr[SB-1], r_dr});
                mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, r_gain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // product >> 23 rounds toward minus infinity
    assign mul_gained = mul_p[SB+GAIN_FRAC-1:GAIN_FRAC];

    lpl_mul #(
        .A_W (AW),
        .B_W (MUL_B_W)
    ) u_lpl_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign div_start = (r_state == S_GAIN_CHK) && (r_env > thr);

    lpl_div #(
        .W (SB)
    ) u_lpl_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (thr),
        .i_divisor  (r_env),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // ring: slot is read at accept and overwritten in the next cycle, from S_ENV_MUL
    assign ring_we = (r_state == S_ENV_MUL) && !dly_zero;

    lpl_ram #(
        .WIDTH (2 * SB),
        .DEPTH (MAX_DELAY)
    ) u_lpl_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_pos),
        .i_wdata ({r_l, r_r}),
        .i_raddr (r_pos),
        .o_rdata (ring_rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = r_en ? S_ENV_MUL : S_DONE;
                end
            end
            S_ENV_MUL:  n_state = S_ENV_UPD;
            S_ENV_UPD:  n_state = S_GAIN_CHK;
            S_GAIN_CHK: n_state = div_start ? S_DIV : S_MUL_L;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_MUL_L;
                end
            end
            S_MUL_L:    n_state = S_MUL_R;
            S_MUL_R:    n_state = S_FIN;
            S_FIN:      n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= RST_ENABLE;
            r_st  <= RST_STEREO;
            r_thr <= RST_THRESHOLD;
            r_att <= RST_ATTACK;
            r_rel <= RST_RELEASE;
            r_dly <= RST_DELAY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:    r_en  <= i_cfg_data[0];
                CFG_STEREO:    r_st  <= i_cfg_data[0];
                CFG_THRESHOLD: r_thr <= i_cfg_data[THR_W-1:0];
                CFG_ATTACK:    r_att <= i_cfg_data[COEFF_W-1:0];
                CFG_RELEASE:   r_rel <= i_cfg_data[COEFF_W-1:0];
                CFG_DELAY:     r_dly <= i_cfg_data[DLY_W-1:0];
                default: ;
            endcase
        end
    end

    // envelope and ring pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env     <= '0;
            r_pos     <= '0;
            r_wrapped <= 1'b0;
        end else if (cfg_clear || (in_accept && !r_en)) begin
            r_env     <= '0;
            r_pos     <= '0;
            r_wrapped <= 1'b0;
        end else begin
            if (ring_we) begin
                r_pos <= pos_wrap ? '0 : pos_inc[PW-1:0];
                if (pos_wrap) begin
                    r_wrapped <= 1'b1;
                end
            end
            if (r_state == S_ENV_UPD) begin
                r_env <= env_next;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_l    <= i_frame.sample_left;
            r_r    <= in_r_eff;
            r_peak <= in_peak;
            if (!r_en) begin
                r_res_l <= i_frame.sample_left;
                r_res_r <= in_r_eff;
                r_gain  <= UNITY_GAIN;
            end
        end
        if (r_state == S_ENV_MUL) begin
            // a slot not yet written since the last clear reads as silence
            if (dly_zero) begin
                r_dl <= r_l;
                r_dr <= r_r;
            end else if (r_wrapped) begin
                r_dl <= ring_rdata[2*SB-1:SB];
                r_dr <= ring_rdata[SB-1:0];
            end else begin
                r_dl <= '0;
                r_dr <= '0;
            end
        end
        if ((r_state == S_GAIN_CHK) && !div_start) begin
            r_gain <= UNITY_GAIN;
        end
        if ((r_state == S_DIV) && div_done) begin
            r_gain <= {1'b0, div_quot};
        end
        if (r_state == S_MUL_R) begin
            r_res_l <= mul_gained;
        end
        if (r_state == S_FIN) begin
            r_res_r <= r_st ? mul_gained : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_ov <= 1'b1;
        end else if (o_result.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_l <= r_res_l;
            r_out_r <= r_res_r;
            r_out_g <= r_gain;
        end
    end

    assign i_frame.ready         = (r_state == S_IDLE);
    assign o_result.valid        = r_ov;
    assign o_result.out_left     = r_out_l;
    assign o_result.out_right    = r_out_r;
    assign o_result.gain_applied = r_out_g;

endmodule

`default_nettype wire

[design/lpl_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module lpl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

[design/lpl_mul.sv]
// Shared signed multiplier with a registered product.
`default_nettype none

module lpl_mul #(
    parameter int A_W = 25,
    parameter int B_W = 26
) (
    input  wire logic                       i_clk,
    input  wire logic signed [A_W-1:0]      i_a,
    input  wire logic signed [B_W-1:0]      i_b,
    output logic      signed [A_W+B_W-1:0]  o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule

`default_nettype wire

[design/lpl_div.sv]
// Restoring divider, one quotient bit per cycle: (dividend << 23) / divisor.
`default_nettype none

module lpl_div
    import lpl_pkg::*;
#(
    parameter int W = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [W-1:0]         i_dividend,
    input  wire logic [W-1:0]         i_divisor,
    output logic                      o_done,
    output logic [GAIN_FRAC-1:0]      o_quot
);

    localparam int CW = $clog2(GAIN_FRAC);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [W-1:0]         r_rem;
    logic [W-1:0]         r_div;
    logic [GAIN_FRAC-1:0] r_quot;

    logic [W:0]           trial;
    logic [W:0]           diff;
    logic                 fits;

    // dividend < divisor on entry, so the partial remainder stays below the divisor
    assign trial = {r_rem, 1'b0};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(GAIN_FRAC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[W-1:0] : trial[W-1:0];
            r_quot <= {r_quot[GAIN_FRAC-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

[design/lpl_chk.sv]
// Port-level checks for the limiter core, bound to the top level.
`default_nettype none

module lpl_chk
    import lpl_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   i_in_ready,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [SAMPLE_BITS-1:0] i_out_left,
    input wire logic [SAMPLE_BITS-1:0] i_out_right,
    input wire logic [GAIN_W-1:0]      i_gain
);

    // reset empties the result slot and opens the input
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("result valid or input closed after reset");

    // one frame at a time: the input closes after each request
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input still open right after a request");

    // gain never exceeds unity
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_gain <= UNITY_GAIN))
        else $error("gain above unity");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_left) && $stable(i_out_right) && $stable(i_gain)))
        else $error("stalled result changed");

endmodule

bind lookahead_peak_limiter_core lpl_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_lpl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_frame.valid),
    .i_in_ready  (i_frame.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_left  (o_result.out_left),
    .i_out_right (o_result.out_right),
    .i_gain      (o_result.gain_applied)
);

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for lookahead_peak_limiter_core: directed table, then random phases.
`default_nettype none

module tb;
    import lpl_pkg::*;

    localparam int RING_DEPTH     = 1024;
    localparam int SETTLE_CYCLES  = 36;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 9;
    localparam int PHASE_FRAMES   = 104;

    // indexes past the end of the register list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    localparam logic signed [23:0] FULL_POS = 24'sh7FFFFF;
    localparam logic signed [23:0] FULL_NEG = 24'sh800000;

    typedef struct packed {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic [23:0]        gain;
    } limited_frame_t;

    typedef enum bit {ROW_FRAME, ROW_REG} row_kind_e;

    typedef struct {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic signed [23:0]    left;
        logic signed [23:0]    right;
        bit                    known;
        limited_frame_t        want;
    } stim_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    lpl_in_if  #(.SAMPLE_BITS(24)) frame_if ();
    lpl_out_if #(.SAMPLE_BITS(24)) result_if ();

    lookahead_peak_limiter_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_frame    (frame_if),
        .o_result   (result_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // limiter state as seen by the predictor
    logic signed [23:0] ring_left  [RING_DEPTH];
    logic signed [23:0] ring_right [RING_DEPTH];
    int unsigned        ring_pos;
    longint             env_level;
    bit                 cfg_enable;
    bit                 cfg_stereo;
    logic [23:0]        cfg_thr;
    logic [24:0]        cfg_attack;
    logic [24:0]        cfg_release;
    logic [10:0]        cfg_delay;

    limited_frame_t frames_due [$];
    int             mismatches;
    int             results_seen;
    int             quiet_cycles;
    bit             sender_idles;
    bit             sink_idles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_limiter();
        foreach (ring_left[i]) begin
            ring_left[i]  = '0;
            ring_right[i] = '0;
        end
        ring_pos  = 0;
        env_level = 0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_ENABLE: begin
                cfg_enable = val[0];
                if (!val[0])
                    clear_limiter();
            end
            CFG_STEREO:    cfg_stereo  = val[0];
            CFG_THRESHOLD: cfg_thr     = val[23:0];
            CFG_ATTACK:    cfg_attack  = val[24:0];
            CFG_RELEASE:   cfg_release = val[24:0];
            CFG_DELAY: begin
                cfg_delay = val[10:0];
                clear_limiter();
            end
            default: ;
        endcase
    endfunction

    function automatic logic [23:0] scale_sample(longint s, longint g);
        longint p;
        p = s * g;
        return 24'(p >>> GAIN_FRAC);
    endfunction

    // envelope, gain and delay ring for one frame request
    function automatic limited_frame_t limit_frame(logic signed [23:0] l_in,
                                                   logic signed [23:0] r_in);
        longint         l, r, pk, mr, thr, ta, tr, dl, dr, gain;
        int unsigned    d;
        limited_frame_t res;
        l = l_in;
        r = cfg_stereo ? longint'(r_in) : 0;
        if (!cfg_enable) begin
            clear_limiter();
            res.left  = l_in;
            res.right = 24'(r);
            res.gain  = UNITY_GAIN;
            return res;
        end
        thr = (cfg_thr > UNITY_GAIN) ? UNITY_GAIN : cfg_thr;
        ta  = (cfg_attack > COEFF_ONE) ? COEFF_ONE : cfg_attack;
        tr  = (cfg_release > COEFF_ONE) ? COEFF_ONE : cfg_release;
        d   = cfg_delay;
        if (d > RING_DEPTH)
            d = RING_DEPTH;

        pk = (l < 0) ? -l : l;
        mr = (r < 0) ? -r : r;
        if (mr > pk)
            pk = mr;
        if (pk > env_level)
            env_level += (ta * (pk - env_level)) >>> COEFF_FRAC;
        else
            env_level -= (tr * (env_level - pk)) >>> COEFF_FRAC;

        if (env_level > thr)
            gain = (thr <<< GAIN_FRAC) / env_level;
        else
            gain = UNITY_GAIN;

        if (d == 0) begin
            dl = l;
            dr = r;
        end else begin
            if (ring_pos >= d)
                ring_pos = 0;
            dl = ring_left[ring_pos];
            dr = ring_right[ring_pos];
            ring_left[ring_pos]  = 24'(l);
            ring_right[ring_pos] = 24'(r);
            ring_pos = (ring_pos + 1) % d;
        end

        res.left  = scale_sample(dl, gain);
        res.right = cfg_stereo ? scale_sample(dr, gain) : '0;
        res.gain  = 24'(gain);
        return res;
    endfunction

    function automatic void flag(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want)
            flag($sformatf("result %0d %s: expected 0x%06h, got 0x%06h",
                           results_seen, name, want, got));
    endfunction

    // result checker and watchdog
    always @(posedge i_clk) begin
        limited_frame_t want;
        if (!i_rst_n || (frame_if.valid && frame_if.ready) ||
            (result_if.valid && result_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("lookahead_peak_limiter_core verification failed");
            $finish;
        end
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (frames_due.size() == 0) begin
                flag($sformatf("result %0d with no request pending: L=0x%06h R=0x%06h G=0x%06h",
                               results_seen, result_if.out_left, result_if.out_right,
                               result_if.gain_applied));
            end else begin
                want = frames_due.pop_front();
                check_field("out_left", want.left, result_if.out_left);
                check_field("out_right", want.right, result_if.out_right);
                check_field("gain_applied", want.gain, result_if.gain_applied);
            end
            results_seen++;
        end
    end

    // receiver stalls in bursts
    initial begin
        int stall_left;
        stall_left = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_idles && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 11);
            if (stall_left > 0) begin
                result_if.ready <= 1'b0;
                stall_left--;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_frame(input logic signed [23:0] l, input logic signed [23:0] r,
                              input bit known, input limited_frame_t want);
        limited_frame_t guess;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            frame_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        frame_if.valid        <= 1'b1;
        frame_if.sample_left  <= l;
        frame_if.sample_right <= r;
        @(posedge i_clk);
        while (!frame_if.ready)
            @(posedge i_clk);
        guess = limit_frame(l, r);
        frames_due.push_back(known ? want : guess);
    endtask

    // drop valid, let every pending result drain, then allow the pipeline to go quiet
    task automatic settle();
        frame_if.valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic stim_row_t frame_row(logic signed [23:0] l, logic signed [23:0] r);
        stim_row_t row;
        row.kind  = ROW_FRAME;
        row.idx   = '0;
        row.data  = '0;
        row.left  = l;
        row.right = r;
        row.known = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic stim_row_t known_row(logic signed [23:0] l, logic signed [23:0] r,
                                            logic signed [23:0] el, logic signed [23:0] er,
                                            logic [23:0] eg);
        stim_row_t row;
        row            = frame_row(l, r);
        row.known      = 1'b1;
        row.want.left  = el;
        row.want.right = er;
        row.want.gain  = eg;
        return row;
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row      = frame_row(0, 0);
        row.kind = ROW_REG;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    function automatic logic signed [23:0] pick_sample();
        logic signed [23:0] s;
        case ($urandom_range(0, 9))
            0: s = $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
            1, 2, 3, 4: begin
                // loud enough to drive the envelope over most thresholds
                s = 24'($urandom_range(7500000, 8388607));
                if ($urandom_range(0, 1))
                    s = -s;
            end
            5, 6: s = 24'($urandom_range(0, 4095) - 2048);
            default: s = 24'($urandom);
        endcase
        return s;
    endfunction

    function automatic logic [24:0] pick_coeff();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return COEFF_ONE;
            2: return 25'($urandom_range(COEFF_ONE, 25'h1FFFFFF));
            3, 4: return 25'($urandom_range(0, 1 << 20));
            default: return 25'($urandom_range(0, COEFF_ONE));
        endcase
    endfunction

    function automatic logic [10:0] pick_delay();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 11'd1;
            2: return 11'(RING_DEPTH);
            3: return 11'($urandom_range(0, 2047));
            default: return 11'($urandom_range(2, 16));
        endcase
    endfunction

    task automatic retune_limiter();
        logic [CFG_DATA_W-1:0] w;
        if ($urandom_range(0, 1)) begin
            w    = CFG_DATA_W'($urandom);
            w[0] = ($urandom_range(0, 9) != 0);
            write_reg(CFG_ENABLE, w);
        end
        if ($urandom_range(0, 1))
            write_reg(CFG_STEREO, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 1)) begin
            w = CFG_DATA_W'($urandom);
            case ($urandom_range(0, 5))
                0: w[23:0] = 24'd8389;
                1: w[23:0] = UNITY_GAIN;
                2: w[23:0] = 24'($urandom_range(UNITY_GAIN, 24'hFFFFFF));
                default: w[23:0] = 24'($urandom_range(8389, UNITY_GAIN));
            endcase
            write_reg(CFG_THRESHOLD, w);
        end
        if ($urandom_range(0, 1))
            write_reg(CFG_ATTACK, pick_coeff());
        if ($urandom_range(0, 1))
            write_reg(CFG_RELEASE, pick_coeff());
        if ($urandom_range(0, 1)) begin
            w        = CFG_DATA_W'($urandom);
            w[10:0]  = pick_delay();
            write_reg(CFG_DELAY, w);
        end
        if ($urandom_range(0, 4) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                      CFG_DATA_W'($urandom));
    endtask

    initial begin
        stim_row_t plan [$];
        i_rst_n               <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_idx               <= '0;
        cfg_data              <= '0;
        frame_if.valid        <= 1'b0;
        frame_if.sample_left  <= '0;
        frame_if.sample_right <= '0;
        mismatches   = 0;
        results_seen = 0;
        quiet_cycles = 0;
        sender_idles = 1'b1;
        sink_idles   = 1'b1;
        cfg_enable   = RST_ENABLE;
        cfg_stereo   = RST_STEREO;
        cfg_thr      = RST_THRESHOLD;
        cfg_attack   = RST_ATTACK;
        cfg_release  = RST_RELEASE;
        cfg_delay    = RST_DELAY;
        clear_limiter();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ring reads silence right after reset
        plan.push_back(known_row(0, 0, 0, 0, UNITY_GAIN));
        plan.push_back(frame_row(FULL_POS, FULL_NEG));
        plan.push_back(frame_row(FULL_NEG, FULL_POS));
        plan.push_back(reg_row(CFG_SPARE_A, 25'h1FFFFFF));
        plan.push_back(reg_row(CFG_SPARE_B, 25'h0AAAAAA));
        plan.push_back(reg_row(CFG_DELAY, 0));
        plan.push_back(reg_row(CFG_ATTACK, COEFF_ONE));
        plan.push_back(frame_row(FULL_POS, 0));
        plan.push_back(frame_row(0, -1));
        // bypass, stereo then mono
        plan.push_back(reg_row(CFG_ENABLE, 0));
        plan.push_back(known_row(FULL_NEG, FULL_POS, FULL_NEG, FULL_POS, UNITY_GAIN));
        plan.push_back(reg_row(CFG_STEREO, 0));
        plan.push_back(known_row(123, 456, 123, 0, UNITY_GAIN));
        plan.push_back(reg_row(CFG_ENABLE, 1));
        // instant attack on a full-scale peak: gain equals the threshold
        plan.push_back(known_row(FULL_NEG, 777, -7919358, 0, 24'd7919358));
        plan.push_back(reg_row(CFG_THRESHOLD, 25'hFFFFFF));
        plan.push_back(known_row(FULL_NEG, 5, FULL_NEG, 0, UNITY_GAIN));
        plan.push_back(reg_row(CFG_STEREO, 1));
        plan.push_back(reg_row(CFG_ATTACK, 25'h1FFFFFF));
        plan.push_back(reg_row(CFG_RELEASE, 25'h1FFFFFF));
        plan.push_back(reg_row(CFG_THRESHOLD, 8389));
        plan.push_back(frame_row(4000000, -5000000));
        plan.push_back(known_row(0, 0, 0, 0, UNITY_GAIN));
        plan.push_back(reg_row(CFG_DELAY, 2047));
        plan.push_back(frame_row(1, -1));
        plan.push_back(frame_row(-2, 2));
        // frames stored in mono come back with a zero right sample after the switch
        plan.push_back(reg_row(CFG_DELAY, 3));
        plan.push_back(reg_row(CFG_STEREO, 0));
        plan.push_back(frame_row(1000, 2000));
        plan.push_back(frame_row(-3000, 4000));
        plan.push_back(frame_row(5000, -6000));
        plan.push_back(reg_row(CFG_STEREO, 1));
        plan.push_back(frame_row(7000, 8000));
        plan.push_back(frame_row(-9000, 10000));
        plan.push_back(frame_row(11000, -12000));
        plan.push_back(frame_row(1, 1));
        plan.push_back(reg_row(CFG_ATTACK, 0));
        plan.push_back(reg_row(CFG_RELEASE, 0));
        plan.push_back(reg_row(CFG_THRESHOLD, UNITY_GAIN));
        plan.push_back(reg_row(CFG_DELAY, 1));
        plan.push_back(frame_row(FULL_POS, FULL_POS));
        plan.push_back(frame_row(FULL_NEG, FULL_NEG));
        // enabling an enabled limiter keeps the ring
        plan.push_back(reg_row(CFG_ENABLE, 1));
        plan.push_back(frame_row(3, 4));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                settle();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_frame(plan[i].left, plan[i].right, plan[i].known, plan[i].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            retune_limiter();
            if (phase == PHASES - 1) begin
                sender_idles = 1'b0;
                sink_idles   = 1'b0;
            end else begin
                sender_idles = ($urandom_range(0, 3) != 0);
                sink_idles   = ($urandom_range(0, 3) != 0);
            end
            repeat (PHASE_FRAMES)
                send_frame(pick_sample(), pick_sample(), 1'b0, '0);
        end

        settle();
        if (mismatches == 0)
            $display("lookahead_peak_limiter_core verification clean");
        else
            $display("lookahead_peak_limiter_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
design/lpl_pkg.sv
design/lpl_in_if.sv
design/lpl_out_if.sv
design/lpl_ram.sv
design/lpl_mul.sv
design/lpl_div.sv
design/lookahead_peak_limiter_core.sv
design/lpl_chk.sv
dv/tb.sv
